// ===== hw/rtl/svf_pkg.sv =====
package svf_pkg;

    // Fixed formats of the filter network.
    localparam int CHANNELS        = 2;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;
    localparam int STATE_BITS      = 32;
    localparam int COEF_FRAC       = 26;
    localparam int VAL_BITS        = STATE_BITS + 1;
    localparam int MAG_BITS        = STATE_BITS;
    localparam int DIGIT_BITS      = 8;
    localparam int NUM_REGS        = 6;
    localparam int REG_IDX_BITS    = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_A1,
        REG_A2,
        REG_A3,
        REG_M0,
        REG_M1,
        REG_M2
    } t_reg_idx;

    typedef struct packed {
        logic start;
        logic first;
    } t_mac_cmd;

    // Width of the multiply-accumulate register for a given coefficient width.
    function automatic int f_acc_bits(input int cb);
        int ndig;
        int qb;
        ndig = (cb + DIGIT_BITS - 1) / DIGIT_BITS;
        qb   = ndig * DIGIT_BITS + MAG_BITS + 1 - COEF_FRAC;
        return ((qb > STATE_BITS) ? qb : STATE_BITS) + 3;
    endfunction

endpackage

// ===== hw/rtl/svf_if.sv =====
interface svf_smp_if import svf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface svf_res_if import svf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface svf_cfg_if import svf_pkg::*; #(
    parameter int COEF_BITS = COEF_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [REG_IDX_BITS-1:0] index;
    logic [COEF_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/stereo_state_variable_filter_unit.sv =====
// Stereo trapezoidal state-variable filter. Each item on i_smp is one left and
// one right sample; each item on o_res is the filtered pair, saturated to the
// sample width. The filter type is set only by the six coefficients a1, a2, a3,
// m0, m1 and m2 on i_cfg (index 0 to 5, 26 fraction bits); write them while no
// item is in flight. Per channel seven products are formed one after another
// on a single digit-serial multiplier that takes eight coefficient bits per
// clock, then rounds each product and adds it to the running sum. A finished
// pair waits in the output register while the next item is taken.
module stereo_state_variable_filter_unit import svf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svf_smp_if.sink    i_smp,
    svf_res_if.source  o_res,
    svf_cfg_if.sink    i_cfg
);

    localparam int ACC_BITS = f_acc_bits(COEF_BITS);
    localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [ACC_BITS-1:0] ST_MAX = $signed(ACC_BITS'({(STATE_BITS-1){1'b1}}));
    localparam logic signed [ACC_BITS-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [ACC_BITS-1:0] SM_MAX =
        $signed(ACC_BITS'({(SAMPLE_BITS-1){1'b1}}));
    localparam logic signed [ACC_BITS-1:0] SM_MIN = ~SM_MAX;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ISSUE,
        S_WAIT,
        S_UPD,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_A1_S1,
        OP_A2_V3,
        OP_A2_S1,
        OP_A3_V3,
        OP_M0_V0,
        OP_M1_V1,
        OP_M2_V2
    } t_op;

    t_state                        r_state, n_state;
    t_op                           r_op, n_op;
    logic [CH_BITS-1:0]            r_ch, n_ch;
    logic signed [SAMPLE_BITS-1:0] r_smp [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] n_smp [CHANNELS];
    logic signed [VAL_BITS-1:0]    r_v3, n_v3;
    logic signed [STATE_BITS-1:0]  r_v1, n_v1;
    logic signed [STATE_BITS-1:0]  r_v2, n_v2;
    logic signed [STATE_BITS-1:0]  r_s1 [CHANNELS];
    logic signed [STATE_BITS-1:0]  n_s1 [CHANNELS];
    logic signed [STATE_BITS-1:0]  r_s2 [CHANNELS];
    logic signed [STATE_BITS-1:0]  n_s2 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_y [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] n_y [CHANNELS];
    logic                          r_ovalid, n_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_lout, n_lout;
    logic signed [SAMPLE_BITS-1:0] r_rout, n_rout;

    logic signed [COEF_BITS-1:0]   w_coef_bank [NUM_REGS];
    t_mac_cmd                      w_cmd;
    logic signed [COEF_BITS-1:0]   w_coef;
    logic signed [VAL_BITS-1:0]    w_operand;
    logic signed [STATE_BITS-1:0]  w_init;
    logic                          w_mac_done;
    logic signed [ACC_BITS-1:0]    w_acc;
    logic signed [STATE_BITS-1:0]  w_acc_state;
    logic signed [SAMPLE_BITS-1:0] w_acc_smp;
    logic signed [STATE_BITS-1:0]  w_s1;
    logic signed [STATE_BITS-1:0]  w_s2;
    logic signed [VAL_BITS-1:0]    w_v0;
    logic signed [STATE_BITS+1:0]  w_i1;
    logic signed [STATE_BITS+1:0]  w_i2;

    function automatic logic signed [STATE_BITS-1:0] f_sat_int(
        input logic signed [STATE_BITS+1:0] x
    );
        logic [2:0] top;
        top = x[STATE_BITS+1:STATE_BITS-1];
        if (top == 3'b000 || top == 3'b111) begin
            return x[STATE_BITS-1:0];
        end else if (x[STATE_BITS+1]) begin
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    endfunction

    svf_coef_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_coef  (w_coef_bank)
    );

    svf_serial_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_coef     (w_coef),
        .i_operand  (w_operand),
        .i_acc_init (w_init),
        .o_done     (w_mac_done),
        .o_acc      (w_acc)
    );

    assign w_s1 = r_s1[r_ch];
    assign w_s2 = r_s2[r_ch];
    assign w_v0 = VAL_BITS'(r_smp[r_ch]);

    // Node values are clamped to the state width, the mix to the sample width.
    assign w_acc_state = (w_acc > ST_MAX) ? STATE_BITS'(ST_MAX) :
                         (w_acc < ST_MIN) ? STATE_BITS'(ST_MIN) : w_acc[STATE_BITS-1:0];
    assign w_acc_smp   = (w_acc > SM_MAX) ? SAMPLE_BITS'(SM_MAX) :
                         (w_acc < SM_MIN) ? SAMPLE_BITS'(SM_MIN) : w_acc[SAMPLE_BITS-1:0];

    assign w_i1 = $signed({r_v1[STATE_BITS-1], r_v1, 1'b0}) - (STATE_BITS + 2)'(w_s1);
    assign w_i2 = $signed({r_v2[STATE_BITS-1], r_v2, 1'b0}) - (STATE_BITS + 2)'(w_s2);

    // Each product either opens a new sum (from zero or from the second
    // integrator) or adds to the one in progress.
    always_comb begin
        w_coef      = w_coef_bank[REG_A1];
        w_operand   = VAL_BITS'(w_s1);
        w_init      = '0;
        w_cmd.first = 1'b0;
        case (r_op)
            OP_A1_S1: begin
                w_cmd.first = 1'b1;
            end
            OP_A2_V3: begin
                w_coef    = w_coef_bank[REG_A2];
                w_operand = r_v3;
            end
            OP_A2_S1: begin
                w_coef      = w_coef_bank[REG_A2];
                w_init      = w_s2;
                w_cmd.first = 1'b1;
            end
            OP_A3_V3: begin
                w_coef    = w_coef_bank[REG_A3];
                w_operand = r_v3;
            end
            OP_M0_V0: begin
                w_coef      = w_coef_bank[REG_M0];
                w_operand   = w_v0;
                w_cmd.first = 1'b1;
            end
            OP_M1_V1: begin
                w_coef    = w_coef_bank[REG_M1];
                w_operand = VAL_BITS'(r_v1);
            end
            OP_M2_V2: begin
                w_coef    = w_coef_bank[REG_M2];
                w_operand = VAL_BITS'(r_v2);
            end
            default: begin
                w_coef = w_coef_bank[REG_A1];
            end
        endcase
        w_cmd.start = (r_state == S_ISSUE);
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_ch     = r_ch;
        n_smp    = r_smp;
        n_v3     = r_v3;
        n_v1     = r_v1;
        n_v2     = r_v2;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_y      = r_y;
        n_ovalid = r_ovalid & ~o_res.ready;
        n_lout   = r_lout;
        n_rout   = r_rout;
        case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    n_smp[0] = i_smp.left_sample;
                    n_smp[1] = i_smp.right_sample;
                    n_ch     = '0;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                n_v3    = w_v0 - VAL_BITS'(w_s2);
                n_op    = OP_A1_S1;
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_mac_done) begin
                    case (r_op)
                        OP_A2_V3: begin
                            n_v1 = w_acc_state;
                        end
                        OP_A3_V3: begin
                            n_v2 = w_acc_state;
                        end
                        OP_M2_V2: begin
                            n_y[r_ch] = w_acc_smp;
                        end
                        default: begin
                        end
                    endcase
                    if (r_op == OP_M2_V2) begin
                        n_state = S_UPD;
                    end else begin
                        n_op    = t_op'(r_op + 3'd1);
                        n_state = S_ISSUE;
                    end
                end
            end
            S_UPD: begin
                n_s1[r_ch] = f_sat_int(w_i1);
                n_s2[r_ch] = f_sat_int(w_i2);
                if (r_ch == CH_BITS'(CHANNELS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_ch    = CH_BITS'(r_ch + 1'b1);
                    n_state = S_PREP;
                end
            end
            S_DONE: begin
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_lout   = r_y[0];
                    n_rout   = r_y[1];
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_A1_S1;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
            r_s1     <= '{default: '0};
            r_s2     <= '{default: '0};
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_smp    <= n_smp;
            r_v3     <= n_v3;
            r_v1     <= n_v1;
            r_v2     <= n_v2;
            r_y      <= n_y;
            r_lout   <= n_lout;
            r_rout   <= n_rout;
        end
    end

    assign i_smp.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_ovalid;
    assign o_res.left_out  = r_lout;
    assign o_res.right_out = r_rout;

    a_accept_starts_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> (r_state == S_PREP && r_ch == CH_BITS'(0)))
        else $error("accepted item did not start on the first channel");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == S_WAIT))
        else $error("multiplier finished while the sequencer was not waiting");

    a_issue_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |=> !w_mac_done)
        else $error("multiplier reported done right after a start");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished pair was not placed in the output register");

endmodule

// ===== hw/rtl/svf_coef_regs.sv =====
module svf_coef_regs import svf_pkg::*; #(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    svf_cfg_if.sink                     i_cfg,
    output logic signed [COEF_BITS-1:0] o_coef [NUM_REGS]
);

    logic signed [COEF_BITS-1:0] r_coef [NUM_REGS];

    assign i_cfg.ready = 1'b1;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '{default: '0};
        end else if (i_cfg.valid && (i_cfg.index < REG_IDX_BITS'(NUM_REGS))) begin
            r_coef[i_cfg.index] <= $signed(i_cfg.data);
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== hw/rtl/svf_serial_mac.sv =====
module svf_serial_mac import svf_pkg::*; #(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_mac_cmd                                i_cmd,
    input  logic signed [COEF_BITS-1:0]             i_coef,
    input  logic signed [VAL_BITS-1:0]              i_operand,
    input  logic signed [STATE_BITS-1:0]            i_acc_init,
    output logic                                    o_done,
    output logic signed [f_acc_bits(COEF_BITS)-1:0] o_acc
);

    localparam int NDIG      = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int CPAD      = NDIG * DIGIT_BITS;
    localparam int PROD_BITS = CPAD + MAG_BITS;
    localparam int Q_BITS    = PROD_BITS + 1 - COEF_FRAC;
    localparam int ACC_BITS  = f_acc_bits(COEF_BITS);
    localparam int CNT_BITS  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam logic [PROD_BITS:0] HALF = (PROD_BITS + 1)'(1) << (COEF_FRAC - 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_RND,
        M_ACC
    } t_mstate;

    t_mstate                     r_mstate, n_mstate;
    logic [CPAD-1:0]             r_cmag, n_cmag;
    logic [MAG_BITS-1:0]         r_vmag, n_vmag;
    logic                        r_neg, n_neg;
    logic [PROD_BITS-1:0]        r_p, n_p;
    logic [Q_BITS-1:0]           r_q, n_q;
    logic signed [ACC_BITS-1:0]  r_acc, n_acc;
    logic [CNT_BITS-1:0]         r_dig, n_dig;
    logic                        r_done, n_done;

    logic [COEF_BITS-1:0]           w_cabs;
    logic [VAL_BITS-1:0]            w_vabs;
    logic [DIGIT_BITS-1:0]          w_digit;
    logic [MAG_BITS+DIGIT_BITS-1:0] w_pp;
    logic [PROD_BITS:0]             w_rsum;
    logic signed [ACC_BITS-1:0]     w_qext;
    logic signed [ACC_BITS-1:0]     w_term;

    // Products are formed on magnitudes; the sign is put back after rounding,
    // which gives rounding half away from zero.
    assign w_cabs  = i_coef[COEF_BITS-1] ? (~i_coef + 1'b1) : i_coef;
    assign w_vabs  = i_operand[VAL_BITS-1] ? (~i_operand + 1'b1) : i_operand;
    assign w_digit = r_cmag[CPAD-1 -: DIGIT_BITS];
    assign w_pp    = r_vmag * w_digit;
    assign w_rsum  = {1'b0, r_p} + HALF;
    assign w_qext  = $signed(ACC_BITS'(r_q));
    assign w_term  = r_neg ? -w_qext : w_qext;

    always_comb begin
        n_mstate = r_mstate;
        n_cmag   = r_cmag;
        n_vmag   = r_vmag;
        n_neg    = r_neg;
        n_p      = r_p;
        n_q      = r_q;
        n_acc    = r_acc;
        n_dig    = r_dig;
        n_done   = 1'b0;
        case (r_mstate)
            M_IDLE: begin
                if (i_cmd.start) begin
                    n_cmag   = CPAD'(w_cabs);
                    n_vmag   = w_vabs[MAG_BITS-1:0];
                    n_neg    = i_coef[COEF_BITS-1] ^ i_operand[VAL_BITS-1];
                    n_p      = '0;
                    n_dig    = '0;
                    n_mstate = M_MUL;
                    if (i_cmd.first) begin
                        n_acc = ACC_BITS'(i_acc_init);
                    end
                end
            end
            M_MUL: begin
                // Most significant coefficient digit first.
                n_p    = (r_p << DIGIT_BITS) + PROD_BITS'(w_pp);
                n_cmag = r_cmag << DIGIT_BITS;
                n_dig  = CNT_BITS'(r_dig + 1'b1);
                if (r_dig == CNT_BITS'(NDIG - 1)) begin
                    n_mstate = M_RND;
                end
            end
            M_RND: begin
                n_q      = w_rsum[PROD_BITS -: Q_BITS];
                n_mstate = M_ACC;
            end
            M_ACC: begin
                n_acc    = r_acc + w_term;
                n_done   = 1'b1;
                n_mstate = M_IDLE;
            end
            default: begin
                n_mstate = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_mstate <= n_mstate;
            r_done   <= n_done;
            r_cmag   <= n_cmag;
            r_vmag   <= n_vmag;
            r_neg    <= n_neg;
            r_p      <= n_p;
            r_q      <= n_q;
            r_acc    <= n_acc;
            r_dig    <= n_dig;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ===== tb/tb.sv =====
module tb;
    import svf_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int CB = COEF_BITS_DEF;
    // Sets the length of the wait at the end of the run, in clock cycles.
    localparam int ITEM_CYCLES = 2 + 2 * (2 + 7 * ((CB + DIGIT_BITS - 1) / DIGIT_BITS + 4));
    localparam longint UNITY = longint'(1) <<< COEF_FRAC;
    localparam longint COEF_MAX = (longint'(1) <<< (CB - 1)) - 1;
    localparam longint COEF_MIN = -COEF_MAX - 1;
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = REG_IDX_BITS'(NUM_REGS);
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = '1;
    localparam int RUN_LIMIT = 2000000;

    typedef enum {
        RESP_LOWPASS,
        RESP_HIGHPASS,
        RESP_BANDPASS,
        RESP_NOTCH,
        RESP_PEAK
    } t_response;

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n;

    svf_smp_if #(.SAMPLE_BITS(SB)) smp_bus ();
    svf_res_if #(.SAMPLE_BITS(SB)) res_bus ();
    svf_cfg_if #(.COEF_BITS(CB))   cfg_bus ();

    stereo_state_variable_filter_unit #(
        .SAMPLE_BITS (SB),
        .COEF_BITS   (CB)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #2 i_clk = ~i_clk;

    // Filter state and coefficients as the block should hold them.
    longint coef_reg  [NUM_REGS];
    longint integ_one [CHANNELS];
    longint integ_two [CHANNELS];
    t_pair  expected_pairs [$];

    int  errors;
    int  items_sent;
    int  results_checked;
    int  coef_writes;
    int  hold_off;
    bit  calm;

    initial begin
        foreach (coef_reg[i]) coef_reg[i] = 0;
        foreach (integ_one[i]) begin
            integ_one[i] = 0;
            integ_two[i] = 0;
        end
    end

    function automatic longint clamp(longint x, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // Exact product, scaled down by the coefficient fraction with rounding
    // half away from zero.
    function automatic longint scaled_product(longint c, longint v);
        logic [127:0] mag;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic         neg;
        neg = (c < 0) != (v < 0);
        ua  = (c < 0) ? 64'(-c) : 64'(c);
        ub  = (v < 0) ? 64'(-v) : 64'(v);
        mag = {64'd0, ua} * {64'd0, ub};
        mag = (mag + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
        if (mag > (128'd1 << 61)) mag = 128'd1 << 61;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic logic signed [SB-1:0] filter_sample(int ch, longint x);
        longint s1;
        longint s2;
        longint diff;
        longint band;
        longint low;
        longint mix;
        s1   = integ_one[ch];
        s2   = integ_two[ch];
        diff = x - s2;
        band = clamp(scaled_product(coef_reg[REG_A1], s1)
                     + scaled_product(coef_reg[REG_A2], diff), STATE_BITS);
        low  = clamp(s2 + scaled_product(coef_reg[REG_A2], s1)
                     + scaled_product(coef_reg[REG_A3], diff), STATE_BITS);
        integ_one[ch] = clamp(2 * band - s1, STATE_BITS);
        integ_two[ch] = clamp(2 * low - s2, STATE_BITS);
        mix = scaled_product(coef_reg[REG_M0], x) + scaled_product(coef_reg[REG_M1], band)
              + scaled_product(coef_reg[REG_M2], low);
        mix = clamp(mix, SB);
        return mix[SB-1:0];
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        errors++;
        $display("mismatch on %s at result %0d: expected %0d, got %0d",
                 what, results_checked, want, got);
    endtask

    // Results are checked before the item accepted on the same edge is predicted.
    always @(posedge i_clk) begin : monitor
        t_pair want;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch("result with no item outstanding", 0,
                                    longint'(res_bus.left_out));
                end else begin
                    want = expected_pairs.pop_front();
                    if (res_bus.left_out !== want.left)
                        report_mismatch("left_out", longint'(want.left),
                                        longint'(res_bus.left_out));
                    if (res_bus.right_out !== want.right)
                        report_mismatch("right_out", longint'(want.right),
                                        longint'(res_bus.right_out));
                end
                results_checked++;
            end
            if (smp_bus.valid && smp_bus.ready) begin
                want.left  = filter_sample(0, longint'(smp_bus.left_sample));
                want.right = filter_sample(1, longint'(smp_bus.right_sample));
                expected_pairs = {expected_pairs, want};
                items_sent++;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                if (cfg_bus.index < NUM_REGS)
                    coef_reg[cfg_bus.index] = longint'(signed'(cfg_bus.data));
                coef_writes++;
            end
        end
    end

    // Receiving side: random stall bursts, plus a long hold-off on request.
    initial begin : sink_side
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off > 0) begin
                res_bus.ready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [SB-1:0] rand_sample();
        logic signed [SB-1:0] s;
        s = SB'($urandom);
        case ($urandom_range(0, 7))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2, 3:    s = s >>> $urandom_range(4, SB - 2);
            default: ;
        endcase
        return s;
    endfunction

    function automatic longint pick_coef();
        case ($urandom_range(0, 5))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return 0;
            3:       return UNITY;
            4:       return -UNITY;
            default: return longint'($urandom);
        endcase
    endfunction

    // Offers one item and returns at the edge that takes it, valid left high.
    task automatic offer_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            smp_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        smp_bus.valid        <= 1'b1;
        smp_bus.left_sample  <= l;
        smp_bus.right_sample <= r;
        @(posedge i_clk);
        while (!smp_bus.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        smp_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pairs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_coef(logic [REG_IDX_BITS-1:0] idx, longint val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CB'(val);
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    task automatic load_coefs(longint a1, longint a2, longint a3,
                              longint m0, longint m1, longint m2);
        drain();
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        write_coef(REG_A3, a3);
        write_coef(REG_M0, m0);
        write_coef(REG_M1, m1);
        write_coef(REG_M2, m2);
        cfg_bus.valid <= 1'b0;
    endtask

    // Coefficients of a stable trapezoidal filter for gain g and damping k,
    // both with the coefficient fraction.
    task automatic set_response(t_response resp, longint g, longint k);
        longint a1;
        longint a2;
        longint a3;
        a1 = (UNITY * UNITY) / (UNITY + ((g * (g + k)) >>> COEF_FRAC));
        a2 = (g * a1) >>> COEF_FRAC;
        a3 = (g * a2) >>> COEF_FRAC;
        case (resp)
            RESP_LOWPASS:  load_coefs(a1, a2, a3, 0, 0, UNITY);
            RESP_HIGHPASS: load_coefs(a1, a2, a3, UNITY, -k, -UNITY);
            RESP_BANDPASS: load_coefs(a1, a2, a3, 0, UNITY, 0);
            RESP_NOTCH:    load_coefs(a1, a2, a3, UNITY, -k, 0);
            default:       load_coefs(a1, a2, a3, UNITY, -k, -2 * UNITY);
        endcase
    endtask

    task automatic random_response();
        set_response(t_response'($urandom_range(0, 4)),
                     longint'($urandom_range(UNITY / 200, 4 * UNITY)),
                     longint'($urandom_range(UNITY / 10, 2 * UNITY)));
    endtask

    task automatic full_scale_burst();
        offer_pair(SAMPLE_MAX, SAMPLE_MIN);
        offer_pair(SAMPLE_MIN, SAMPLE_MAX);
        offer_pair(SAMPLE_MAX, SAMPLE_MAX);
        offer_pair('0, '0);
    endtask

    // With every coefficient at zero after reset, all outputs must be zero.
    task automatic test_reset_coefs();
        offer_pair('0, '0);
        offer_pair(SAMPLE_MAX, SAMPLE_MIN);
        offer_pair(SAMPLE_MIN, SAMPLE_MAX);
        offer_pair(SB'(1), -SB'(1));
        offer_pair(-SB'(1), SB'(1));
    endtask

    // Straight pass-through, then writes to the unused indexes must change nothing.
    task automatic test_register_map();
        load_coefs(0, 0, 0, UNITY, 0, 0);
        write_coef(REG_SPARE_LO, COEF_MIN);
        write_coef(REG_SPARE_HI, COEF_MAX);
        cfg_bus.valid <= 1'b0;
        offer_pair(SAMPLE_MAX, SAMPLE_MIN);
        offer_pair(SB'(12345), -SB'(54321));
    endtask

    // Full-scale coefficients drive the nodes, the states and the mix into saturation.
    task automatic test_full_scale();
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        full_scale_burst();
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        full_scale_burst();
        load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
        full_scale_burst();
    endtask

    task automatic test_responses();
        for (int s = 0; s < 6; s++) begin
            if (s < 5)
                set_response(t_response'(s), longint'($urandom_range(UNITY / 200, 4 * UNITY)),
                             longint'($urandom_range(UNITY / 10, 2 * UNITY)));
            else
                random_response();
            repeat (60) offer_pair(rand_sample(), rand_sample());
        end
    endtask

    task automatic test_random_coefs();
        repeat (2) begin
            load_coefs(longint'($urandom), longint'($urandom), longint'($urandom),
                       longint'($urandom), longint'($urandom), longint'($urandom));
            repeat (50) offer_pair(rand_sample(), rand_sample());
        end
        load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
        repeat (50) offer_pair(rand_sample(), rand_sample());
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_stall();
        random_response();
        hold_off = 600;
        repeat (30) offer_pair(rand_sample(), rand_sample());
    endtask

    task automatic test_steady_tail();
        random_response();
        calm = 1'b1;
        repeat (100) offer_pair(rand_sample(), rand_sample());
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        smp_bus.valid        <= 1'b0;
        smp_bus.left_sample  <= '0;
        smp_bus.right_sample <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= '0;
        cfg_bus.data         <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_coefs();
        test_register_map();
        test_full_scale();
        test_responses();
        test_random_coefs();
        test_output_stall();
        test_steady_tail();

        drain();
        repeat (2 * ITEM_CYCLES) @(posedge i_clk);

        $display("%0d sample pairs filtered, %0d results checked, %0d coefficient writes",
                 items_sent, results_checked, coef_writes);
        $display("covered zeroed and unused registers, full-scale saturation, five responses, "
                 , "random coefficients and a long output stall");
        if (errors == 0 && expected_pairs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, expected_pairs.size());
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("run did not finish in time");
        $display("status: fail");
        $finish;
    end

endmodule

// ===== stereo_state_variable_filter_unit.f =====
hw/rtl/svf_pkg.sv
hw/rtl/svf_if.sv
hw/rtl/svf_coef_regs.sv
hw/rtl/svf_serial_mac.sv
hw/rtl/stereo_state_variable_filter_unit.sv
tb/tb.sv
